[src/kab_pkg.sv]
//------------------------------------------------------------------------------
// kab_pkg
// Shared types, constants and helpers of the angle/bias Kalman filter.
//------------------------------------------------------------------------------
package kab_pkg;

	localparam int unsigned NoiseW = 31;
	localparam int unsigned DataW = 32;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [NoiseW-1:0] RESET_ANGLE_NOISE = 31'd16777;
	localparam logic [NoiseW-1:0] RESET_BIAS_NOISE = 31'd50332;
	localparam logic [NoiseW-1:0] RESET_MEASURE_NOISE = 31'd20971520;
	localparam logic signed [DataW-1:0] ONE_Q24 = 32'sd16777216;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_BIAS_NOISE = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MEASURE_NOISE = 2'd2;

	// divider request and reply
	typedef struct packed {
		logic start;
		logic signed [DataW-1:0] num;
		logic signed [DataW:0] den;
	} kab_div_req_t;

	typedef struct packed {
		logic done;
		logic signed [DataW-1:0] quo;
	} kab_div_rsp_t;

	// saturate a 66-bit signed value to 32 bits
	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		begin
			hi = 66'sd2147483647;
			lo = -66'sd2147483648;
			if (v > hi) sat32 = 32'sh7fffffff;
			else if (v < lo) sat32 = 32'sh80000000;
			else sat32 = v[DataW-1:0];
		end
	endfunction

	// round half up, shift by 16
	function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
		logic signed [65:0] t;
		begin
			t = x + 66'sd32768;
			rnd16 = t >>> 16;
		end
	endfunction

	// round half up, shift by 24
	function automatic logic signed [65:0] rnd24(input logic signed [65:0] x);
		logic signed [65:0] t;
		begin
			t = x + 66'sd8388608;
			rnd24 = t >>> 24;
		end
	endfunction

endpackage

[src/kab_div.sv]
//------------------------------------------------------------------------------
// kab_div
// Signed restoring divider, one quotient bit per cycle, trunc toward zero,
// saturated to 32 bits. Numerator is scaled by 2^24. Denominator positive.
//------------------------------------------------------------------------------
module kab_div
	import kab_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input kab_div_req_t req,
	output kab_div_rsp_t rsp
);

	localparam int unsigned QW = 56;
	localparam int unsigned CntW = $clog2(QW + 1);

	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic [QW-1:0] num_q;
	logic [DataW:0] den_q;
	logic [DataW+1:0] rem_q;
	logic neg_q;
	logic done_q;
	logic signed [DataW-1:0] quo_q;

	logic [DataW+1:0] rem_sh;
	logic [DataW+1:0] rem_sub;
	logic [QW-1:0] mag_in;
	logic signed [QW:0] sq;

	always_comb begin
		rem_sh = {rem_q[DataW:0], num_q[QW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		mag_in = req.num[DataW-1] ? QW'(-{{(QW-DataW){req.num[DataW-1]}}, req.num}) << 24
			: QW'({{(QW-DataW){1'b0}}, req.num}) << 24;
		sq = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	end

	// shift and subtract sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(QW);
				num_q <= mag_in;
				den_q <= req.den;
				rem_q <= '0;
				neg_q <= req.num[DataW-1];
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quo_q <= sat32(66'(sq));
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (!rem_sub[DataW+1]) begin
						rem_q <= rem_sub;
						num_q <= {num_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	no_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider start lost");
	done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("divider done without work");

endmodule

[src/kalman_angle_bias_filter.sv]
//------------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state angle/gyro-bias Kalman filter, shared multiplier and divider
// under a step sequencer.
//
// channel  direction  handshake       payload
// in       input      in_valid/stall  measured_angle gyro_rate time_step restart
// out      output     out_valid/stall filtered_angle bias_estimate
// cfg      input      cfg_we          cfg_index cfg_data
//
// a transaction runs 10 multiply steps on the one shared 34x34 multiplier,
// plus two divisions (56 quotient bits each) on the shared divider; a
// non-positive innovation covariance skips both divisions
// reset restores state and noise registers at once, no clearing pass
// in_stall is high from acceptance until the result is taken
//------------------------------------------------------------------------------
module kalman_angle_bias_filter
	import kab_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [24:0] measured_angle,
	input logic signed [24:0] gyro_rate,
	input logic [15:0] time_step,
	input logic restart,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] bias_estimate,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [NoiseW-1:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_RATE, S_ANG, S_H, S_P00, S_P11, S_Y, S_DIV0, S_W0, S_DIV1, S_W1,
		S_UA, S_UB, S_U00, S_U01, S_U10, S_U11, S_OUT
	} state_t;

	state_t state_q;
	logic [NoiseW-1:0] qa_q, qb_q, r_q;
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] meas_q, gyro_q, rate_q, y_q, k0_q, k1_q, pp00_q, pp01_q;
	logic signed [65:0] h_q;
	logic [15:0] dt_q;
	logic out_valid_q;

	// shared multiplier operands
	logic signed [33:0] ma, mb;
	logic signed [65:0] prod;
	kab_div_req_t dreq;
	kab_div_rsp_t drsp;
	logic signed [65:0] s_full;

	assign s_full = 66'(p00_q) + 66'($signed({1'b0, r_q}));

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_ANG: begin ma = 34'({1'b0, dt_q}); mb = 34'(rate_q); end
			S_H: begin ma = 34'({1'b0, dt_q}); mb = 34'(p11_q); end
			S_P00: begin
				ma = 34'({1'b0, dt_q});
				mb = 34'(h_q - 66'(p01_q) - 66'(p10_q) + 66'($signed({1'b0, qa_q})));
			end
			S_P11: begin ma = 34'({1'b0, dt_q}); mb = 34'($signed({1'b0, qb_q})); end
			S_UA: begin ma = 34'(k0_q); mb = 34'(y_q); end
			S_UB: begin ma = 34'(k1_q); mb = 34'(y_q); end
			S_U00: begin ma = 34'(k0_q); mb = 34'(pp00_q); end
			S_U01: begin ma = 34'(k0_q); mb = 34'(pp01_q); end
			S_U10: begin ma = 34'(k1_q); mb = 34'(pp00_q); end
			S_U11: begin ma = 34'(k1_q); mb = 34'(pp01_q); end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = 66'(ma) * 66'(mb);
		dreq.start = (state_q == S_DIV0) || (state_q == S_DIV1);
		dreq.num = (state_q == S_DIV1) ? p10_q : p00_q;
		dreq.den = s_full[32:0];
	end

	kab_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// noise registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= RESET_ANGLE_NOISE;
			qb_q <= RESET_BIAS_NOISE;
			r_q <= RESET_MEASURE_NOISE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANGLE_NOISE: qa_q <= cfg_data;
				REG_BIAS_NOISE: qb_q <= cfg_data;
				REG_MEASURE_NOISE: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// step sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			ang_q <= '0;
			bias_q <= '0;
			p00_q <= ONE_Q24;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= ONE_Q24;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					meas_q <= 32'(measured_angle);
					gyro_q <= 32'(gyro_rate);
					dt_q <= time_step;
					if (restart) begin
						ang_q <= '0;
						bias_q <= '0;
						p00_q <= ONE_Q24;
						p01_q <= '0;
						p10_q <= '0;
						p11_q <= ONE_Q24;
					end
					state_q <= S_RATE;
				end
				S_RATE: begin
					rate_q <= sat32(66'(gyro_q) - 66'(bias_q));
					state_q <= S_ANG;
				end
				S_ANG: begin
					ang_q <= sat32(66'(ang_q) + rnd16(prod));
					state_q <= S_H;
				end
				S_H: begin
					h_q <= rnd16(prod);
					state_q <= S_P00;
				end
				S_P00: begin
					p00_q <= sat32(66'(p00_q) + rnd16(prod));
					p01_q <= sat32(66'(p01_q) - h_q);
					p10_q <= sat32(66'(p10_q) - h_q);
					state_q <= S_P11;
				end
				S_P11: begin
					p11_q <= sat32(66'(p11_q) + rnd16(prod));
					state_q <= S_Y;
				end
				S_Y: begin
					y_q <= sat32(66'(meas_q) - 66'(ang_q));
					pp00_q <= p00_q;
					pp01_q <= p01_q;
					if (s_full <= 0) begin
						k0_q <= '0;
						k1_q <= '0;
						state_q <= S_UA;
					end else state_q <= S_DIV0;
				end
				S_DIV0: state_q <= S_W0;
				S_W0: if (drsp.done) begin
					k0_q <= drsp.quo;
					state_q <= S_DIV1;
				end
				S_DIV1: state_q <= S_W1;
				S_W1: if (drsp.done) begin
					k1_q <= drsp.quo;
					state_q <= S_UA;
				end
				S_UA: begin
					ang_q <= sat32(66'(ang_q) + rnd24(prod));
					state_q <= S_UB;
				end
				S_UB: begin
					bias_q <= sat32(66'(bias_q) + rnd24(prod));
					state_q <= S_U00;
				end
				S_U00: begin
					p00_q <= sat32(66'(p00_q) - rnd24(prod));
					state_q <= S_U01;
				end
				S_U01: begin
					p01_q <= sat32(66'(p01_q) - rnd24(prod));
					state_q <= S_U10;
				end
				S_U10: begin
					p10_q <= sat32(66'(p10_q) - rnd24(prod));
					state_q <= S_U11;
				end
				S_U11: begin
					p11_q <= sat32(66'(p11_q) - rnd24(prod));
					out_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign filtered_angle = ang_q;
	assign bias_estimate = bias_q;

	valid_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_OUT) else $error("result shown outside output state");
	no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> in_stall) else $error("input open while result pending");
	div_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == S_W0 || state_q == S_W1)) else $error("stray divider result");

endmodule
